>>> rtl/tsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

    localparam int unsigned ANG_W          = 9;
    localparam int unsigned EPS_W          = 32;
    localparam int unsigned X_W            = 32;
    localparam int unsigned X2_W           = 36;
    localparam int unsigned MAG_W          = 40;
    localparam int unsigned SUM_W          = 44;
    localparam int unsigned CNT_W          = 7;
    localparam int unsigned OUT_W          = 36;
    localparam int unsigned CNT_OUT_W      = 5;
    localparam int unsigned FRAC_BITS      = 28;
    localparam int unsigned NUM_W          = 48;
    localparam int unsigned QUO_W          = 46;
    localparam int unsigned RECIP_SHIFT    = 58;
    localparam int unsigned DIV_W          = 16;
    localparam int unsigned DEF_MAX_ITER   = 24;

    localparam logic [EPS_W-1:0] EPS_RESET = 32'd268;
    localparam logic [63:0]      PI_Q60    = 64'h3243F6A8885A308D;
    localparam logic [63:0]      DEG_Q60   = (PI_Q60 + 64'd90) / 64'd180;

    typedef struct packed {
        logic                    valid;
        logic [X2_W-1:0]         x2;
        logic [MAG_W-1:0]        mag;
        logic                    neg;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic                    big;
    } t_item;

endpackage

`default_nettype wire

>>> rtl/taylor_sine_degrees.sv
`timescale 1ns / 1ps
`default_nettype none

// Sine of a whole-degree angle by its Maclaurin series in Q28 fixed point.
// Pulse start with i_angle_deg; busy is always low, so a new angle can be
// given every clock. Each beat flows through a pipeline: a front end that
// registers x and then x squared, a block per series term (MAX_ITERATIONS
// terms, each a split multiply, a reciprocal multiply and a remainder
// correction), and an output register that drives o_done. Terms past the
// stop point pass through untouched. The result shows for one cycle with
// o_done and cannot be held back. Write i_cfg_wdata with i_cfg_we only
// while no beat is in flight; it sets the stop threshold (unsigned Q28,
// reset 268).
module taylor_sine_degrees #(
    parameter int unsigned MAX_ITERATIONS = tsd_pkg::DEF_MAX_ITER
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [tsd_pkg::ANG_W-1:0]         i_angle_deg,
    input  wire logic                              i_cfg_we,
    input  wire logic [tsd_pkg::EPS_W-1:0]         i_cfg_wdata,
    output logic                                   o_done,
    output logic signed [tsd_pkg::OUT_W-1:0]       o_sine_value,
    output logic [tsd_pkg::CNT_OUT_W-1:0]          o_term_count,
    output logic                                   o_limit_hit
);

    logic [tsd_pkg::EPS_W-1:0] r_epsilon;
    tsd_pkg::t_item            w_item [MAX_ITERATIONS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon <= tsd_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            r_epsilon <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    tsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_angle_deg (i_angle_deg),
        .i_epsilon   (r_epsilon),
        .o_item      (w_item[0])
    );

    for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_term
        tsd_iter #(
            .STEP (g)
        ) u_iter (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_epsilon (r_epsilon),
            .i_item    (w_item[g]),
            .o_item    (w_item[g+1])
        );
    end

    tsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item[MAX_ITERATIONS]),
        .o_done       (o_done),
        .o_sine_value (o_sine_value),
        .o_term_count (o_term_count),
        .o_limit_hit  (o_limit_hit)
    );

`ifndef SYNTHESIS
    localparam logic [tsd_pkg::CNT_OUT_W-1:0] CAP_CNT = tsd_pkg::CNT_OUT_W'(MAX_ITERATIONS);

    a_limit_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_limit_hit |-> o_term_count == CAP_CNT)
        else $error("limit flag without full term count");

    a_eps_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_cfg_we) |-> $stable(r_epsilon))
        else $error("threshold changed without a write");

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy while results stream");
`endif

endmodule

`default_nettype wire

>>> rtl/tsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tsd_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [tsd_pkg::ANG_W-1:0]    i_angle_deg,
    input  wire logic [tsd_pkg::EPS_W-1:0]    i_epsilon,
    output tsd_pkg::t_item                    o_item
);

    logic [72:0]                 w_rad;
    logic [63:0]                 w_sq;
    logic [tsd_pkg::X_W-1:0]     r_x;
    logic                        r_v1;
    tsd_pkg::t_item              r_item;
    tsd_pkg::t_item              n_item;

    // degrees to radians, rounded
    assign w_rad = 73'(i_angle_deg) * 73'(tsd_pkg::DEG_Q60) + (73'd1 << 31);
    assign w_sq  = 64'(r_x) * 64'(r_x) + (64'd1 << (tsd_pkg::FRAC_BITS - 1));

    always_comb begin
        n_item       = '0;
        n_item.valid = r_v1;
        n_item.x2    = w_sq[tsd_pkg::FRAC_BITS +: tsd_pkg::X2_W];
        n_item.mag   = tsd_pkg::MAG_W'(r_x);
        n_item.neg   = 1'b0;
        n_item.sum   = $signed(tsd_pkg::SUM_W'(r_x));
        n_item.count = '0;
        n_item.big   = (r_x >= i_epsilon);
    end

    always_ff @(posedge i_clk) begin
        r_x    <= w_rad[63:32];
        r_v1   <= i_valid;
        r_item <= n_item;
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_item.valid <= 1'b0;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

>>> rtl/tsd_iter.sv
`timescale 1ns / 1ps
`default_nettype none

module tsd_iter #(
    parameter int unsigned STEP = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [tsd_pkg::EPS_W-1:0]    i_epsilon,
    input  tsd_pkg::t_item                    i_item,
    output tsd_pkg::t_item                    o_item
);

    localparam logic [63:0] DIV   = 64'((2 * STEP + 2) * (2 * STEP + 3));
    localparam logic [63:0] HALF  = DIV >> 1;
    localparam logic [63:0] RECIP = (64'd1 << tsd_pkg::RECIP_SHIFT) / DIV;
    localparam logic [tsd_pkg::DIV_W-1:0] DIV_C  = DIV[tsd_pkg::DIV_W-1:0];
    localparam logic [27:0]               RCP_LO = RECIP[27:0];
    localparam logic [27:0]               RCP_HI = RECIP[55:28];

    tsd_pkg::t_item r_s1, r_s2, r_s3, r_s4, r_s5, r_s6;
    tsd_pkg::t_item n_s6;

    logic [55:0]                  r_pa_lo, r_pa_hi;
    logic [75:0]                  w_prod;
    logic [tsd_pkg::NUM_W-1:0]    r_num2, r_num3, r_num4;
    logic [51:0]                  r_ll, r_lh, r_hl, r_hh;
    logic [103:0]                 w_qf;
    logic [tsd_pkg::QUO_W-1:0]    r_q0;
    logic [61:0]                  w_qd;
    logic [61:0]                  w_rem;
    logic [tsd_pkg::QUO_W-1:0]    w_q;
    logic [tsd_pkg::MAG_W-1:0]    r_q;

    // term magnitude times x squared, rounded
    assign w_prod = {r_pa_hi, 20'd0} + 76'(r_pa_lo) + (76'd1 << (tsd_pkg::FRAC_BITS - 1));

    // reciprocal multiply, quotient low by at most one
    assign w_qf = 104'(r_ll) + (104'(r_lh) << 28) + (104'(r_hl) << 24) + (104'(r_hh) << 52);

    assign w_qd  = 62'(r_q0) * 62'(DIV_C);
    assign w_rem = 62'(r_num4) - w_qd;
    assign w_q   = (w_rem >= 62'(DIV_C)) ? r_q0 + 1'b1 : r_q0;

    always_comb begin
        n_s6 = r_s5;
        if (r_s5.big) begin
            n_s6.neg   = !r_s5.neg;
            n_s6.mag   = r_q;
            n_s6.sum   = r_s5.neg ? r_s5.sum + $signed(tsd_pkg::SUM_W'(r_q))
                                  : r_s5.sum - $signed(tsd_pkg::SUM_W'(r_q));
            n_s6.count = r_s5.count + 1'b1;
            n_s6.big   = (r_q >= tsd_pkg::MAG_W'(i_epsilon));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1    <= i_item;
        r_pa_lo <= 56'(i_item.mag[19:0]) * 56'(i_item.x2);
        r_pa_hi <= 56'(i_item.mag[39:20]) * 56'(i_item.x2);

        r_s2    <= r_s1;
        r_num2  <= w_prod[tsd_pkg::FRAC_BITS +: tsd_pkg::NUM_W] + HALF[tsd_pkg::NUM_W-1:0];

        r_s3    <= r_s2;
        r_num3  <= r_num2;
        r_ll    <= 52'(r_num2[23:0]) * 52'(RCP_LO);
        r_lh    <= 52'(r_num2[23:0]) * 52'(RCP_HI);
        r_hl    <= 52'(r_num2[47:24]) * 52'(RCP_LO);
        r_hh    <= 52'(r_num2[47:24]) * 52'(RCP_HI);

        r_s4    <= r_s3;
        r_num4  <= r_num3;
        r_q0    <= w_qf[tsd_pkg::RECIP_SHIFT +: tsd_pkg::QUO_W];

        r_s5    <= r_s4;
        r_q     <= w_q[tsd_pkg::MAG_W-1:0];

        r_s6    <= n_s6;

        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
            r_s5.valid <= 1'b0;
            r_s6.valid <= 1'b0;
        end
    end

    assign o_item = r_s6;

endmodule

`default_nettype wire

>>> rtl/tsd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tsd_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  tsd_pkg::t_item                         i_item,
    output logic                                   o_done,
    output logic signed [tsd_pkg::OUT_W-1:0]       o_sine_value,
    output logic [tsd_pkg::CNT_OUT_W-1:0]          o_term_count,
    output logic                                   o_limit_hit
);

    logic [tsd_pkg::SUM_W-1:0]      w_smag;
    logic                           w_sat;
    logic [tsd_pkg::OUT_W-1:0]      n_value;
    logic                           r_done;
    logic [tsd_pkg::OUT_W-1:0]      r_value;
    logic [tsd_pkg::CNT_OUT_W-1:0]  r_count;
    logic                           r_limit;

    assign w_smag = i_item.sum[tsd_pkg::SUM_W-1] ? -i_item.sum : i_item.sum;
    assign w_sat  = |w_smag[tsd_pkg::SUM_W-1:tsd_pkg::OUT_W-1];

    always_comb begin
        if (i_item.sum[tsd_pkg::SUM_W-1]) begin
            n_value = w_sat ? {1'b1, {(tsd_pkg::OUT_W-1){1'b0}}}
                            : -w_smag[tsd_pkg::OUT_W-1:0];
        end else begin
            n_value = w_sat ? {1'b0, {(tsd_pkg::OUT_W-1){1'b1}}}
                            : w_smag[tsd_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_done  <= i_item.valid;
        r_value <= n_value;
        r_count <= i_item.count[tsd_pkg::CNT_OUT_W-1:0];
        r_limit <= i_item.big;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end
    end

    assign o_done       = r_done;
    assign o_sine_value = $signed(r_value);
    assign o_term_count = r_count;
    assign o_limit_hit  = r_limit;

endmodule

`default_nettype wire
